// ===== src/multi_map_key_value_table_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the multi-map key/value table
// Shared forms for the concurrent checks on the block's ports.
// ----------------------------------------------------------------------------
`ifndef MULTI_MAP_KEY_VALUE_TABLE_UNIT_DEFINES_SVH
`define MULTI_MAP_KEY_VALUE_TABLE_UNIT_DEFINES_SVH

// Check that is switched off while reset is high.
`define MMKV_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that also holds across reset.
`define MMKV_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/mmkv_pkg.sv =====
// ----------------------------------------------------------------------------
// mmkv_pkg
// Types, codes and default sizes shared by the multi-map key/value table.
// ----------------------------------------------------------------------------
package mmkv_pkg;

   localparam int NUM_MAPS_DEF      = 16;
   localparam int SLOTS_PER_MAP_DEF = 16;

   localparam int OPCODE_W = 2;
   localparam int MAP_W    = 4;
   localparam int KEY_W    = 64;
   localparam int VAL_W    = 64;
   localparam int STATUS_W = 2;
   localparam int ENTRY_W  = KEY_W + VAL_W;

   // Wide enough to compare a map number against a pool of up to 256 maps.
   localparam int MAP_CMP_W = 9;

   localparam logic [OPCODE_W-1:0] OP_CREATE = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_PUT    = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_GET    = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_MAP   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_MAP_FULL = 2'd2;

   typedef struct packed {
      logic [OPCODE_W-1:0] opcode;
      logic [MAP_W-1:0]    map_id;
      logic [KEY_W-1:0]    lookup_key;
      logic [VAL_W-1:0]    entry_value;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                found;
      logic [VAL_W-1:0]    value_out;
      logic [MAP_W-1:0]    new_map;
   } rsp_type;

   // Hand-over of a finished result from the sequencer to the output stage.
   typedef struct packed {
      logic    push;
      rsp_type data;
   } res_hand_type;

endpackage

// ===== src/mmkv_ram.sv =====
// ----------------------------------------------------------------------------
// mmkv_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mmkv_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/mmkv_seq.sv =====
// ----------------------------------------------------------------------------
// mmkv_seq
// Sequencer: clears the slot memory after reset, hands out map numbers and
// scans one map's slots for put and get, one slot read per cycle.
// ----------------------------------------------------------------------------
module mmkv_seq #(
   parameter int NUM_MAPS      = mmkv_pkg::NUM_MAPS_DEF,
   parameter int SLOTS_PER_MAP = mmkv_pkg::SLOTS_PER_MAP_DEF,
   parameter int TOTAL         = NUM_MAPS * SLOTS_PER_MAP,
   parameter int ADDR_W        = (TOTAL > 1) ? $clog2(TOTAL) : 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  mmkv_pkg::req_type             req_word,
   input  logic                          res_room,
   output mmkv_pkg::res_hand_type        res_hand,
   output logic                          ram_wr_en,
   output logic [ADDR_W-1:0]             ram_wr_addr,
   output logic [mmkv_pkg::ENTRY_W-1:0]  ram_wr_data,
   output logic                          ram_rd_en,
   output logic [ADDR_W-1:0]             ram_rd_addr,
   input  logic [mmkv_pkg::ENTRY_W-1:0]  ram_rd_data
);

   localparam int MAPS_W     = $clog2(NUM_MAPS + 1);
   localparam int SLOT_CNT_W = $clog2(SLOTS_PER_MAP + 1);
   localparam int SLOT_IDX_W = (SLOTS_PER_MAP > 1) ? $clog2(SLOTS_PER_MAP) : 1;
   localparam int NEW_MAP_W  = MAPS_W + mmkv_pkg::MAP_W;

   localparam logic [ADDR_W-1:0]     LAST_ADDR = ADDR_W'(TOTAL - 1);
   localparam logic [SLOT_CNT_W-1:0] SLOT_END  = SLOT_CNT_W'(SLOTS_PER_MAP);
   localparam logic [SLOT_IDX_W-1:0] LAST_SLOT = SLOT_IDX_W'(SLOTS_PER_MAP - 1);

   localparam logic [1:0] ST_CLEAR  = 2'd0;
   localparam logic [1:0] ST_IDLE   = 2'd1;
   localparam logic [1:0] ST_SCAN   = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0]                     state_ff, state_in;
   logic [ADDR_W-1:0]              clr_addr_ff, clr_addr_in;
   logic [MAPS_W-1:0]              maps_used_ff, maps_used_in;
   logic                           chk_valid_ff, chk_valid_in;
   logic [mmkv_pkg::OPCODE_W-1:0]  op_ff, op_in;
   logic [mmkv_pkg::MAP_W-1:0]     map_ff, map_in;
   logic [mmkv_pkg::KEY_W-1:0]     key_ff, key_in;
   logic [mmkv_pkg::VAL_W-1:0]     val_ff, val_in;
   logic [SLOT_CNT_W-1:0]          rd_slot_ff, rd_slot_in;
   logic [SLOT_IDX_W-1:0]          chk_slot_ff, chk_slot_in;
   mmkv_pkg::rsp_type              res_ff, res_in;

   logic [ADDR_W-1:0]              base_addr;
   logic [ADDR_W-1:0]              scan_rd_addr;
   logic [ADDR_W-1:0]              scan_wr_addr;
   logic [mmkv_pkg::KEY_W-1:0]     slot_key;
   logic [mmkv_pkg::VAL_W-1:0]     slot_val;
   logic                           map_ok;
   logic [NEW_MAP_W-1:0]           maps_used_ext;

   assign base_addr    = ADDR_W'(map_ff) * ADDR_W'(SLOTS_PER_MAP);
   assign scan_rd_addr = base_addr + ADDR_W'(rd_slot_ff);
   assign scan_wr_addr = base_addr + ADDR_W'(chk_slot_ff);
   assign slot_key     = ram_rd_data[mmkv_pkg::ENTRY_W-1:mmkv_pkg::VAL_W];
   assign slot_val     = ram_rd_data[mmkv_pkg::VAL_W-1:0];
   assign map_ok       = mmkv_pkg::MAP_CMP_W'(req_word.map_id) <
                         mmkv_pkg::MAP_CMP_W'(NUM_MAPS);
   assign maps_used_ext = NEW_MAP_W'(maps_used_ff);

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      maps_used_in = maps_used_ff;
      chk_valid_in = 1'b0;
      op_in        = op_ff;
      map_in       = map_ff;
      key_in       = key_ff;
      val_in       = val_ff;
      rd_slot_in   = rd_slot_ff;
      chk_slot_in  = chk_slot_ff;
      res_in       = res_ff;

      ram_wr_en    = 1'b0;
      ram_wr_addr  = clr_addr_ff;
      ram_wr_data  = '0;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = scan_rd_addr;

      res_hand.push = 1'b0;
      res_hand.data = res_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            // One slot a cycle goes back to the empty key.
            ram_wr_en = 1'b1;
            if (clr_addr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end else begin
               clr_addr_in = clr_addr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               res_in     = '0;
               op_in      = req_word.opcode;
               map_in     = req_word.map_id;
               key_in     = req_word.lookup_key;
               val_in     = req_word.entry_value;
               rd_slot_in = '0;
               state_in   = ST_FINISH;
               priority if (req_word.opcode == mmkv_pkg::OP_CREATE) begin
                  if (maps_used_ff < MAPS_W'(NUM_MAPS)) begin
                     res_in.new_map = maps_used_ext[mmkv_pkg::MAP_W-1:0];
                     maps_used_in   = maps_used_ff + 1'b1;
                  end else begin
                     res_in.status = mmkv_pkg::STATUS_NO_MAP;
                  end
               end else if ((req_word.opcode == mmkv_pkg::OP_PUT ||
                             req_word.opcode == mmkv_pkg::OP_GET) &&
                            map_ok && (req_word.lookup_key != '0)) begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            // The read of the next slot overlaps the check of the current one.
            if (rd_slot_ff != SLOT_END) begin
               ram_rd_en    = 1'b1;
               rd_slot_in   = rd_slot_ff + 1'b1;
               chk_slot_in  = rd_slot_ff[SLOT_IDX_W-1:0];
               chk_valid_in = 1'b1;
            end
            if (chk_valid_ff) begin
               if ((slot_key == '0) || (slot_key == key_ff)) begin
                  state_in = ST_FINISH;
                  if (op_ff == mmkv_pkg::OP_PUT) begin
                     ram_wr_en   = 1'b1;
                     ram_wr_addr = scan_wr_addr;
                     ram_wr_data = {key_ff, val_ff};
                  end else if (slot_key == key_ff) begin
                     res_in.found     = 1'b1;
                     res_in.value_out = slot_val;
                  end
               end else if (chk_slot_ff == LAST_SLOT) begin
                  state_in = ST_FINISH;
                  if (op_ff == mmkv_pkg::OP_PUT) begin
                     res_in.status = mmkv_pkg::STATUS_MAP_FULL;
                  end
               end
            end
         end
         ST_FINISH: begin
            if (res_room) begin
               res_hand.push = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         maps_used_ff <= '0;
         chk_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         maps_used_ff <= maps_used_in;
         chk_valid_ff <= chk_valid_in;
      end
      op_ff       <= op_in;
      map_ff      <= map_in;
      key_ff      <= key_in;
      val_ff      <= val_in;
      rd_slot_ff  <= rd_slot_in;
      chk_slot_ff <= chk_slot_in;
      res_ff      <= res_in;
   end

endmodule

// ===== src/mmkv_out.sv =====
// ----------------------------------------------------------------------------
// mmkv_out
// Output register: holds one result word until the receiver takes it.
// ----------------------------------------------------------------------------
module mmkv_out (
   input  logic                   clock,
   input  logic                   reset,
   input  mmkv_pkg::res_hand_type res_hand,
   output logic                   res_room,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output mmkv_pkg::rsp_type      rsp_word
);

   logic              rsp_valid_ff, rsp_valid_in;
   mmkv_pkg::rsp_type rsp_word_ff, rsp_word_in;

   // Room when empty, or when the word held now leaves at this edge.
   assign res_room = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      if (res_hand.push) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = res_hand.data;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

// ===== src/multi_map_key_value_table_unit.sv =====
// ----------------------------------------------------------------------------
// multi_map_key_value_table_unit
// Pool of small key/value maps held in one slot memory of key and value.
//
//   channel | direction | handshake          | word
//   req     | in        | req_valid/req_stall | mmkv_pkg::req_type
//   rsp     | out       | rsp_valid/rsp_stall | mmkv_pkg::rsp_type
//
// After reset a clearing pass writes every slot empty, while req_stall stays
// high. A create, or a put or get that needs no scan, goes straight to the
// finish state and hands its result on once the output register has room.
// A put or get scans its map's slots in order up to an empty slot, its key or
// the last slot: the single read port reads one slot a cycle. The next word
// is taken the cycle after a result is handed on, while that result may
// still wait in the output register under rsp_stall.
// ----------------------------------------------------------------------------
module multi_map_key_value_table_unit #(
   parameter int NUM_MAPS      = mmkv_pkg::NUM_MAPS_DEF,
   parameter int SLOTS_PER_MAP = mmkv_pkg::SLOTS_PER_MAP_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  mmkv_pkg::req_type req_word,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output mmkv_pkg::rsp_type rsp_word
);

   localparam int TOTAL  = NUM_MAPS * SLOTS_PER_MAP;
   localparam int ADDR_W = (TOTAL > 1) ? $clog2(TOTAL) : 1;

   logic                          res_room;
   mmkv_pkg::res_hand_type        res_hand;
   logic                          ram_wr_en;
   logic [ADDR_W-1:0]             ram_wr_addr;
   logic [mmkv_pkg::ENTRY_W-1:0]  ram_wr_data;
   logic                          ram_rd_en;
   logic [ADDR_W-1:0]             ram_rd_addr;
   logic [mmkv_pkg::ENTRY_W-1:0]  ram_rd_data;

   mmkv_seq #(
      .NUM_MAPS      (NUM_MAPS),
      .SLOTS_PER_MAP (SLOTS_PER_MAP),
      .TOTAL         (TOTAL),
      .ADDR_W        (ADDR_W)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_word    (req_word),
      .res_room    (res_room),
      .res_hand    (res_hand),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

   mmkv_ram #(
      .WIDTH  (mmkv_pkg::ENTRY_W),
      .DEPTH  (TOTAL),
      .ADDR_W (ADDR_W)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   mmkv_out u_out (
      .clock     (clock),
      .reset     (reset),
      .res_hand  (res_hand),
      .res_room  (res_room),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

endmodule

// ===== src/mmkv_checker.sv =====
// ----------------------------------------------------------------------------
// mmkv_checker
// Port-level checks on the multi-map key/value table, bound to the top level.
// ----------------------------------------------------------------------------
`include "multi_map_key_value_table_unit_defines.svh"

module mmkv_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input mmkv_pkg::rsp_type rsp_word
);

   // A stalled result word stays put.
   `MMKV_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word), "result word changed under stall")

   // Reset empties the output register.
   `MMKV_ASSERT_ALWAYS(a_rsp_reset, clock, reset |=> !rsp_valid, "result valid after reset")

   // Only one word is in work at a time.
   `MMKV_ASSERT(a_busy_after_accept, clock, reset, req_valid && !req_stall |=> req_stall, "input taken while busy")

   // A fresh result only comes out of a busy cycle.
   `MMKV_ASSERT(a_rsp_from_work, clock, reset, $rose(rsp_valid) |-> $past(req_stall), "result without work")

   // A hit is always a clean get.
   `MMKV_ASSERT(a_found_clean, clock, reset, rsp_valid && rsp_word.found |-> rsp_word.status == mmkv_pkg::STATUS_OK && rsp_word.new_map == '0, "found with bad status")

endmodule

bind multi_map_key_value_table_unit mmkv_checker u_checker (.*);

// ===== tb/sv/tb_multi_map_key_value_table_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_multi_map_key_value_table_unit
// Self-checking bench for the pool of key/value maps. A queue of table
// operations is drained by a bursty driver, while a shadow copy of the slot
// store predicts every reply. Replies are taken under a varying stall pattern
// and compared field by field, in order, against the predicted ones.
// ----------------------------------------------------------------------------
module tb_multi_map_key_value_table_unit;

   localparam int NUM_MAPS     = mmkv_pkg::NUM_MAPS_DEF;
   localparam int SLOTS        = mmkv_pkg::SLOTS_PER_MAP_DEF;
   localparam int TOTAL_SLOTS  = NUM_MAPS * SLOTS;
   localparam int ITEM_TARGET  = 1300;
   localparam int DRAIN_CYCLES = 4 * (SLOTS + 2);
   localparam int POOL_SIZE    = 32;
   localparam int OPCODE_W     = mmkv_pkg::OPCODE_W;
   localparam int MAP_W        = mmkv_pkg::MAP_W;
   localparam int KEY_W        = mmkv_pkg::KEY_W;
   localparam int VAL_W        = mmkv_pkg::VAL_W;

   localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

   typedef enum {STALL_NONE, STALL_COIN, STALL_PERIODIC, STALL_RUNS} stall_mode_type;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   mmkv_pkg::req_type req_word  = '0;
   logic              rsp_stall = 1'b0;
   logic              req_stall;
   logic              rsp_valid;
   mmkv_pkg::rsp_type rsp_word;

   // Shadow of the slot store and the map allocator.
   logic [KEY_W-1:0] key_mem [TOTAL_SLOTS];
   logic [VAL_W-1:0] val_mem [TOTAL_SLOTS];
   int unsigned      maps_made;

   mmkv_pkg::req_type table_ops_q [$];
   mmkv_pkg::rsp_type replies_due [$];
   logic [KEY_W-1:0]  key_pool [POOL_SIZE];

   int unsigned errors         = 0;
   int unsigned words_accepted = 0;
   int unsigned total_words    = 0;
   int unsigned ops_counted    = 0;
   bit          req_taken      = 1'b0;

   multi_map_key_value_table_unit #(
      .NUM_MAPS      (NUM_MAPS),
      .SLOTS_PER_MAP (SLOTS)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic mmkv_pkg::rsp_type apply_table_op(input mmkv_pkg::req_type w);
      mmkv_pkg::rsp_type r;
      int unsigned       base;
      bit                done;
      r    = '0;
      base = int'(w.map_id) * SLOTS;
      done = 1'b0;
      case (w.opcode)
         mmkv_pkg::OP_CREATE: begin
            if (maps_made < NUM_MAPS) begin
               r.new_map = MAP_W'(maps_made);
               maps_made++;
            end else begin
               r.status = mmkv_pkg::STATUS_NO_MAP;
            end
         end
         mmkv_pkg::OP_PUT: begin
            // A zero key marks an empty slot, so putting it changes nothing.
            if (w.lookup_key != '0 && int'(w.map_id) < NUM_MAPS) begin
               for (int s = 0; s < SLOTS && !done; s++) begin
                  if (key_mem[base + s] == '0) begin
                     key_mem[base + s] = w.lookup_key;
                     val_mem[base + s] = w.entry_value;
                     done = 1'b1;
                  end else if (key_mem[base + s] == w.lookup_key) begin
                     val_mem[base + s] = w.entry_value;
                     done = 1'b1;
                  end
               end
               if (!done) r.status = mmkv_pkg::STATUS_MAP_FULL;
            end
         end
         mmkv_pkg::OP_GET: begin
            if (int'(w.map_id) < NUM_MAPS) begin
               for (int s = 0; s < SLOTS && !done; s++) begin
                  if (key_mem[base + s] == '0) begin
                     done = 1'b1;
                  end else if (key_mem[base + s] == w.lookup_key) begin
                     r.found     = 1'b1;
                     r.value_out = val_mem[base + s];
                     done = 1'b1;
                  end
               end
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic logic [KEY_W-1:0] pick_key(input int unsigned map);
      int unsigned span;
      // The lower maps draw on fewer pool keys; the upper ones use the whole pool and overflow.
      span = (map < NUM_MAPS / 2) ? 10 : POOL_SIZE;
      if ($urandom_range(0, 15) == 0) return {$urandom, $urandom};
      return key_pool[$urandom_range(0, span - 1)];
   endfunction

   function automatic logic [VAL_W-1:0] pick_value();
      case ($urandom_range(0, 15))
         0:       return '0;
         1:       return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   task automatic queue_op(input logic [OPCODE_W-1:0] op, input int unsigned map,
                           input logic [KEY_W-1:0] key, input logic [VAL_W-1:0] val);
      mmkv_pkg::req_type w;
      w.opcode      = op;
      w.map_id      = MAP_W'(map);
      w.lookup_key  = key;
      w.entry_value = val;
      table_ops_q.push_back(w);
      if (op != OP_UNUSED) ops_counted++;
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
         errors++;
      end
   endtask

   task automatic build_stimulus();
      int unsigned map;
      int unsigned n;
      int unsigned start;
      int unsigned fill;
      // Directed: extremes, every opcode and the corner cases of the scan.
      queue_op(mmkv_pkg::OP_GET, 0, 64'd1, '0);
      queue_op(mmkv_pkg::OP_PUT, 0, '0, '1);
      queue_op(mmkv_pkg::OP_GET, 0, '0, '0);
      queue_op(OP_UNUSED, NUM_MAPS - 1, '1, '1);
      queue_op(mmkv_pkg::OP_CREATE, 0, '0, '0);
      queue_op(mmkv_pkg::OP_PUT, 0, '1, '1);
      queue_op(mmkv_pkg::OP_GET, 0, '1, '0);
      queue_op(mmkv_pkg::OP_PUT, 0, 64'd1, '0);
      queue_op(mmkv_pkg::OP_PUT, 0, 64'd1, 64'h5555_5555_5555_5555);
      queue_op(mmkv_pkg::OP_GET, 0, 64'd1, '0);
      queue_op(mmkv_pkg::OP_GET, 0, 64'd2, '0);
      queue_op(mmkv_pkg::OP_PUT, NUM_MAPS - 1, 64'h8000_0000_0000_0000,
               64'hAAAA_AAAA_AAAA_AAAA);
      queue_op(mmkv_pkg::OP_GET, NUM_MAPS - 1, 64'h8000_0000_0000_0000, '0);
      queue_op(mmkv_pkg::OP_GET, NUM_MAPS - 1, 64'h7FFF_FFFF_FFFF_FFFF, '0);
      queue_op(mmkv_pkg::OP_CREATE, '1, '1, '1);
      queue_op(mmkv_pkg::OP_GET, 5, '1, '0);
      queue_op(mmkv_pkg::OP_CREATE, 0, '0, '0);

      // Random sequences of creates, puts, gets, fills and some noise.
      while (ops_counted < ITEM_TARGET) begin
         map = $urandom_range(0, NUM_MAPS - 1);
         n   = $urandom_range(1, 8);
         case ($urandom_range(0, 99)) inside
            [0:4]: begin
               repeat ($urandom_range(1, 4))
                  queue_op(mmkv_pkg::OP_CREATE, map, pick_value(), pick_value());
            end
            [5:44]: begin
               repeat (n) queue_op(mmkv_pkg::OP_PUT, map, pick_key(map), pick_value());
            end
            [45:84]: begin
               repeat (n) queue_op(mmkv_pkg::OP_GET, map, pick_key(map), pick_value());
            end
            [85:92]: begin
               // Distinct keys in a row, which can run the map into its full state.
               start = $urandom_range(0, POOL_SIZE - 1);
               fill  = $urandom_range(12, 20);
               for (int unsigned i = 0; i < fill; i++)
                  queue_op(mmkv_pkg::OP_PUT, map, key_pool[(start + i) % POOL_SIZE],
                           pick_value());
            end
            default: begin
               repeat (n)
                  queue_op(OPCODE_W'($urandom_range(0, 3)), $urandom_range(0, NUM_MAPS - 1),
                           ($urandom_range(0, 7) == 0) ? '0 : {$urandom, $urandom},
                           pick_value());
            end
         endcase
      end
   endtask

   // Driver: bursts of words with random gaps; a word is held until taken.
   int unsigned burst_left = 0;
   int unsigned gap_left   = 0;

   always @(negedge clock) begin
      logic              drive_valid;
      mmkv_pkg::req_type drive_word;
      drive_valid = req_valid;
      drive_word  = req_word;
      if (reset) begin
         drive_valid = 1'b0;
      end else if (!req_valid || req_taken) begin
         drive_valid = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
         end else if (table_ops_q.size() > 0) begin
            drive_valid = 1'b1;
            drive_word  = table_ops_q.pop_front();
            if (burst_left > 0) burst_left--;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 16);
               case ($urandom_range(0, 15))
                  0:          gap_left = $urandom_range(20, 40);
                  1, 2, 3, 4: gap_left = 0;
                  default:    gap_left = $urandom_range(1, 8);
               endcase
            end
         end
      end
      req_valid <= drive_valid;
      req_word  <= drive_word;
   end

   // Receiver stall: a mode is held for a while, then another is drawn.
   stall_mode_type stall_mode = STALL_NONE;
   int unsigned    mode_left  = 0;
   int unsigned    stall_run  = 0;
   int unsigned    phase      = 0;

   always @(negedge clock) begin
      logic hold;
      if (mode_left == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 3));
         mode_left  = $urandom_range(20, 200);
      end else begin
         mode_left--;
      end
      phase++;
      case (stall_mode)
         STALL_NONE:     hold = 1'b0;
         STALL_COIN:     hold = 1'($urandom_range(0, 1));
         STALL_PERIODIC: hold = (phase % 8) < 5;
         default: begin
            if (stall_run > 0) begin
               stall_run--;
               hold = 1'b1;
            end else begin
               hold = 1'b0;
               if ($urandom_range(0, 3) == 0) stall_run = $urandom_range(1, 12);
            end
         end
      endcase
      rsp_stall <= hold;
   end

   // Monitor: check the reply handed on, then predict for the word taken.
   always @(posedge clock) begin
      mmkv_pkg::rsp_type want;
      if (reset) begin
         req_taken = 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (replies_due.size() == 0) begin
               $display("%0t: reply with none outstanding: expected nothing, actual %p",
                        $time, rsp_word);
               errors++;
            end else begin
               want = replies_due.pop_front();
               check_field("status", 64'(want.status), 64'(rsp_word.status));
               check_field("found", 64'(want.found), 64'(rsp_word.found));
               check_field("value_out", want.value_out, rsp_word.value_out);
               check_field("new_map", 64'(want.new_map), 64'(rsp_word.new_map));
            end
         end
         req_taken = req_valid && !req_stall;
         if (req_taken) begin
            replies_due.push_back(apply_table_op(req_word));
            words_accepted++;
         end
      end
   end

   initial begin
      foreach (key_mem[i]) key_mem[i] = '0;
      foreach (val_mem[i]) val_mem[i] = '0;
      maps_made = 0;
      foreach (key_pool[i]) begin
         key_pool[i] = {$urandom, $urandom};
         if (key_pool[i] == '0) key_pool[i] = 64'd3;
      end
      key_pool[0] = '1;
      key_pool[1] = 64'd1;
      key_pool[2] = 64'h8000_0000_0000_0000;
      build_stimulus();
      total_words = table_ops_q.size();

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      wait (words_accepted == total_words);
      while (replies_due.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (replies_due.size() != 0) begin
         $display("%0t: %0d replies never arrived", $time, replies_due.size());
         errors++;
      end
      if (errors == 0) begin
         $display("** multi_map_key_value_table_unit: PASSED **");
      end else begin
         $display("** multi_map_key_value_table_unit: FAILED **");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("%0t: run did not complete", $time);
      $display("** multi_map_key_value_table_unit: FAILED **");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+src
src/mmkv_pkg.sv
src/mmkv_ram.sv
src/mmkv_seq.sv
src/mmkv_out.sv
src/multi_map_key_value_table_unit.sv
src/mmkv_checker.sv
tb/sv/tb_multi_map_key_value_table_unit.sv
